// File: sv/glyph_bbox_center_core_defines.svh
// Assertion macros shared by the glyph bbox center checker.
`ifndef GLYPH_BBOX_CENTER_CORE_DEFINES_SVH
`define GLYPH_BBOX_CENTER_CORE_DEFINES_SVH

// same-cycle implication
`define GBC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define GBC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/gbc_pkg.sv
// Types, constants and helper functions of the glyph bbox center core.
package gbc_pkg;

    localparam int MAX_SRC_DIM = 64;
    localparam int MAX_OUT_DIM = 64;

    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 2;
    localparam int PIX_W     = 8;

    localparam int SRC_AW = $clog2(MAX_SRC_DIM);
    localparam int SRC_DW = $clog2(MAX_SRC_DIM + 1);
    localparam int OUT_AW = $clog2(MAX_OUT_DIM);
    localparam int OUT_DW = $clog2(MAX_OUT_DIM + 1);
    localparam int ADDR_W = $clog2(MAX_SRC_DIM * MAX_SRC_DIM);
    localparam int CW     = ((SRC_DW > OUT_DW) ? SRC_DW : OUT_DW) + 2;

    localparam logic [PIX_W-1:0] PIX_WHITE = 8'hFF;
    localparam logic [PIX_W-1:0] PIX_BLACK = 8'h00;

    localparam logic [CFG_W-1:0] RST_SRC_DIM = 7'd64;
    localparam logic [CFG_W-1:0] RST_OUT_DIM = 7'd20;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SRC_WIDTH,
        CFG_SRC_HEIGHT,
        CFG_OUT_WIDTH,
        CFG_OUT_HEIGHT
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_OFFS,
        ST_ADDR,
        ST_DATA
    } t_rd_state;

    typedef logic signed [CW-1:0] t_sdim;

    typedef struct packed {
        logic             kind;
        logic [PIX_W-1:0] pixel_in;
    } t_in_word;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_out;
        logic             last_out;
    } t_out_word;

    typedef struct packed {
        logic [SRC_DW-1:0] src_w;
        logic [SRC_DW-1:0] src_h;
        logic [OUT_DW-1:0] out_w;
        logic [OUT_DW-1:0] out_h;
    } t_dims;

    typedef struct packed {
        logic [SRC_DW-1:0] left;
        logic [SRC_AW-1:0] right;
        logic [SRC_DW-1:0] top;
        logic [SRC_AW-1:0] bottom;
        logic              found;
        logic              done;
    } t_box;

    function automatic logic [SRC_DW-1:0] clamp_src(input logic [CFG_W-1:0] v);
        logic [SRC_DW-1:0] r;
        if (v == '0) begin
            r = SRC_DW'(1);
        end else if (int'(v) > MAX_SRC_DIM) begin
            r = SRC_DW'(MAX_SRC_DIM);
        end else begin
            r = SRC_DW'(v);
        end
        return r;
    endfunction

    function automatic logic [OUT_DW-1:0] clamp_out(input logic [CFG_W-1:0] v);
        logic [OUT_DW-1:0] r;
        if (v == '0) begin
            r = OUT_DW'(1);
        end else if (int'(v) > MAX_OUT_DIM) begin
            r = OUT_DW'(MAX_OUT_DIM);
        end else begin
            r = OUT_DW'(v);
        end
        return r;
    endfunction

    function automatic logic [ADDR_W-1:0] addr_of(input logic [SRC_AW-1:0] row,
                                                  input logic [SRC_AW-1:0] col);
        return ADDR_W'(row) * ADDR_W'(MAX_SRC_DIM) + ADDR_W'(col);
    endfunction

endpackage

// File: sv/gbc_frame_ram.sv
// Frame store: one write port, one registered read port.
module gbc_frame_ram #(
    parameter int AW = 12,
    parameter int DW = 8
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [2**AW];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/gbc_loader.sv
// Load side: raster counters, frame start and black-pixel bounding box.
module gbc_loader (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_load,
    input  logic [gbc_pkg::PIX_W-1:0]   i_pixel,
    input  gbc_pkg::t_dims              i_dims,
    output logic                        o_restart,
    output logic [gbc_pkg::ADDR_W-1:0]  o_waddr,
    output gbc_pkg::t_box               o_box
);

    logic [gbc_pkg::SRC_AW-1:0] r_col, n_col, r_row, n_row;
    gbc_pkg::t_box              r_box, n_box;
    logic                       w_start;
    logic [gbc_pkg::SRC_AW-1:0] w_col, w_row;

    always_comb begin
        w_start = i_load && r_box.done;
        w_col   = w_start ? '0 : r_col;
        w_row   = w_start ? '0 : r_row;
        n_box   = r_box;
        if (w_start) begin
            n_box.left   = i_dims.src_w;
            n_box.top    = i_dims.src_h;
            n_box.right  = '0;
            n_box.bottom = '0;
            n_box.found  = 1'b0;
            n_box.done   = 1'b0;
        end
        if (i_pixel == gbc_pkg::PIX_BLACK) begin
            if (!n_box.found) begin
                n_box.left   = gbc_pkg::SRC_DW'(w_col);
                n_box.right  = w_col;
                n_box.top    = gbc_pkg::SRC_DW'(w_row);
                n_box.bottom = w_row;
                n_box.found  = 1'b1;
            end else begin
                if (w_col < n_box.left)   n_box.left   = gbc_pkg::SRC_DW'(w_col);
                if (w_col > n_box.right)  n_box.right  = w_col;
                if (w_row < n_box.top)    n_box.top    = gbc_pkg::SRC_DW'(w_row);
                if (w_row > n_box.bottom) n_box.bottom = w_row;
            end
        end
        n_col = w_col + 1'b1;
        n_row = w_row;
        if (({1'b0, w_col} + 1'b1) >= i_dims.src_w) begin
            n_col = '0;
            if (({1'b0, w_row} + 1'b1) >= i_dims.src_h) begin
                n_row      = '0;
                n_box.done = 1'b1;
            end else begin
                n_row = w_row + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col        <= '0;
            r_row        <= '0;
            r_box.left   <= gbc_pkg::clamp_src(gbc_pkg::RST_SRC_DIM);
            r_box.top    <= gbc_pkg::clamp_src(gbc_pkg::RST_SRC_DIM);
            r_box.right  <= '0;
            r_box.bottom <= '0;
            r_box.found  <= 1'b0;
            r_box.done   <= 1'b0;
        end else if (i_load) begin
            r_col <= n_col;
            r_row <= n_row;
            r_box <= n_box;
        end
    end

    assign o_restart = w_start;
    assign o_waddr   = gbc_pkg::addr_of(w_row, w_col);
    assign o_box     = r_box;

endmodule

// File: sv/gbc_reader.sv
// Read side: output raster counters, placement, store read and output register.
module gbc_reader (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_rd,
    input  logic                        i_restart,
    input  gbc_pkg::t_dims              i_dims,
    input  gbc_pkg::t_box               i_box,
    output logic                        o_busy,
    output logic                        o_re,
    output logic [gbc_pkg::ADDR_W-1:0]  o_raddr,
    input  logic [gbc_pkg::PIX_W-1:0]   i_rdata,
    output logic                        o_out_valid,
    output gbc_pkg::t_out_word          o_out_data,
    input  logic                        i_out_stall
);

    gbc_pkg::t_rd_state r_state, n_state;

    logic [gbc_pkg::OUT_AW-1:0] r_rc, n_rc, r_rr, n_rr;
    logic [gbc_pkg::OUT_AW-1:0] r_rc_cap, r_rr_cap;
    logic                       w_last, r_last;
    gbc_pkg::t_sdim             w_dx, w_dy, w_nx, w_ny, w_offx, w_offy;
    gbc_pkg::t_sdim             r_dx, r_dy, r_offx, r_offy;
    gbc_pkg::t_sdim             w_i, w_j;
    logic                       r_box_ok, w_hit, r_hit;
    logic                       w_out_load;
    logic                       r_out_valid;
    gbc_pkg::t_out_word         r_out;
    logic [gbc_pkg::SRC_AW-1:0] w_sc, w_sr;

    // next raster position of the output image
    always_comb begin
        n_rc   = r_rc + 1'b1;
        n_rr   = r_rr;
        w_last = 1'b0;
        if (({1'b0, r_rc} + 1'b1) >= i_dims.out_w) begin
            n_rc = '0;
            if (({1'b0, r_rr} + 1'b1) >= i_dims.out_h) begin
                n_rr   = '0;
                w_last = 1'b1;
            end else begin
                n_rr = r_rr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rc <= '0;
            r_rr <= '0;
        end else if (i_restart) begin
            r_rc <= '0;
            r_rr <= '0;
        end else if (i_rd) begin
            r_rc <= n_rc;
            r_rr <= n_rr;
        end
    end

    // placement offsets, truncated toward zero
    always_comb begin
        w_dx   = gbc_pkg::t_sdim'(i_box.right) - gbc_pkg::t_sdim'(i_box.left);
        w_dy   = gbc_pkg::t_sdim'(i_box.bottom) - gbc_pkg::t_sdim'(i_box.top);
        w_nx   = gbc_pkg::t_sdim'(i_dims.out_w) - w_dx;
        w_ny   = gbc_pkg::t_sdim'(i_dims.out_h) - w_dy;
        w_offx = (w_nx + gbc_pkg::t_sdim'(w_nx[gbc_pkg::CW-1])) >>> 1;
        w_offy = (w_ny + gbc_pkg::t_sdim'(w_ny[gbc_pkg::CW-1])) >>> 1;
    end

    always_comb begin
        w_i   = gbc_pkg::t_sdim'(r_rc_cap) - r_offx;
        w_j   = gbc_pkg::t_sdim'(r_rr_cap) - r_offy;
        w_hit = r_box_ok && !w_i[gbc_pkg::CW-1] && (w_i <= r_dx)
                         && !w_j[gbc_pkg::CW-1] && (w_j <= r_dy);
        w_sc  = gbc_pkg::SRC_AW'(i_box.left) + w_i[gbc_pkg::SRC_AW-1:0];
        w_sr  = gbc_pkg::SRC_AW'(i_box.top) + w_j[gbc_pkg::SRC_AW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gbc_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        w_out_load = 1'b0;
        unique case (r_state)
            gbc_pkg::ST_IDLE: begin
                if (i_rd) n_state = gbc_pkg::ST_OFFS;
            end
            gbc_pkg::ST_OFFS: begin
                n_state = gbc_pkg::ST_ADDR;
            end
            gbc_pkg::ST_ADDR: begin
                n_state = gbc_pkg::ST_DATA;
            end
            gbc_pkg::ST_DATA: begin
                if (!r_out_valid || !i_out_stall) begin
                    w_out_load = 1'b1;
                    n_state    = gbc_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = gbc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_rd) begin
            r_rc_cap <= r_rc;
            r_rr_cap <= r_rr;
            r_last   <= w_last;
        end
        if (r_state == gbc_pkg::ST_OFFS) begin
            r_dx     <= w_dx;
            r_dy     <= w_dy;
            r_offx   <= w_offx;
            r_offy   <= w_offy;
            r_box_ok <= i_box.done && i_box.found;
        end
        if (r_state == gbc_pkg::ST_ADDR) begin
            r_hit <= w_hit;
        end
        if (w_out_load) begin
            r_out.pixel_out <= r_hit ? i_rdata : gbc_pkg::PIX_WHITE;
            r_out.last_out  <= r_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_busy      = (r_state != gbc_pkg::ST_IDLE);
    assign o_re        = (r_state == gbc_pkg::ST_ADDR) && w_hit;
    assign o_raddr     = gbc_pkg::addr_of(w_sr, w_sc);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// File: sv/glyph_bbox_center_core.sv
// Load word: stored in the accept cycle, one per cycle while no read is in flight, no result word.
// Read word: after accept it steps through offset, address and frame store read, then is
// loaded into the output register; the next word is taken only after that output load,
// which waits while the output register is held by stall.
// Reset (synchronous, active low): counters and box cleared, sizes 64x64 in, 20x20 out.
// The frame store is not cleared; output pixels only come from written entries.
module glyph_bbox_center_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  gbc_pkg::t_in_word               i_in_data,
    output logic                            o_in_stall,
    output logic                            o_out_valid,
    output gbc_pkg::t_out_word              o_out_data,
    input  logic                            i_out_stall,
    input  logic                            i_cfg_we,
    input  logic [gbc_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [gbc_pkg::CFG_W-1:0]       i_cfg_data
);

    logic [gbc_pkg::CFG_W-1:0]  r_src_w, r_src_h, r_out_w, r_out_h;
    gbc_pkg::t_dims             w_dims;
    gbc_pkg::t_box              w_box;
    logic                       w_busy, w_acc, w_load, w_rd, w_restart, w_re;
    logic [gbc_pkg::ADDR_W-1:0] w_waddr, w_raddr;
    logic [gbc_pkg::PIX_W-1:0]  w_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_w <= gbc_pkg::RST_SRC_DIM;
            r_src_h <= gbc_pkg::RST_SRC_DIM;
            r_out_w <= gbc_pkg::RST_OUT_DIM;
            r_out_h <= gbc_pkg::RST_OUT_DIM;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                gbc_pkg::CFG_SRC_WIDTH:  r_src_w <= i_cfg_data;
                gbc_pkg::CFG_SRC_HEIGHT: r_src_h <= i_cfg_data;
                gbc_pkg::CFG_OUT_WIDTH:  r_out_w <= i_cfg_data;
                gbc_pkg::CFG_OUT_HEIGHT: r_out_h <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        w_dims.src_w = gbc_pkg::clamp_src(r_src_w);
        w_dims.src_h = gbc_pkg::clamp_src(r_src_h);
        w_dims.out_w = gbc_pkg::clamp_out(r_out_w);
        w_dims.out_h = gbc_pkg::clamp_out(r_out_h);
    end

    assign w_acc  = i_in_valid && !w_busy;
    assign w_load = w_acc && !i_in_data.kind;
    assign w_rd   = w_acc && i_in_data.kind;

    gbc_loader u_loader (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (w_load),
        .i_pixel   (i_in_data.pixel_in),
        .i_dims    (w_dims),
        .o_restart (w_restart),
        .o_waddr   (w_waddr),
        .o_box     (w_box)
    );

    gbc_frame_ram #(
        .AW (gbc_pkg::ADDR_W),
        .DW (gbc_pkg::PIX_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_load),
        .i_waddr (w_waddr),
        .i_wdata (i_in_data.pixel_in),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    gbc_reader u_reader (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd        (w_rd),
        .i_restart   (w_restart),
        .i_dims      (w_dims),
        .i_box       (w_box),
        .o_busy      (w_busy),
        .o_re        (w_re),
        .o_raddr     (w_raddr),
        .i_rdata     (w_rdata),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

    assign o_in_stall = w_busy;

endmodule

// File: sv/gbc_checker.sv
// Port-level checker for the glyph bbox center core, with its bind.
`include "glyph_bbox_center_core_defines.svh"

module gbc_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input gbc_pkg::t_in_word  i_in_data,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input gbc_pkg::t_out_word o_out_data,
    input logic               i_out_stall
);

    logic w_rd_acc;
    assign w_rd_acc = i_in_valid && !o_in_stall && i_in_data.kind;

    `GBC_ASSERT_NXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid, "output word dropped")
    `GBC_ASSERT_NXT(a_out_stable, o_out_valid && i_out_stall, $stable(o_out_data), "output word changed")
    `GBC_ASSERT_NXT(a_rd_busy, w_rd_acc, o_in_stall, "input taken while read in flight")
    `GBC_ASSERT_IMP(a_out_cause, $rose(o_out_valid), $past(w_rd_acc, 4), "output word without read")

endmodule

bind glyph_bbox_center_core gbc_checker u_gbc_checker (.*);

// File: bench/glyph_bbox_center_core_test.sv
// Self-checking bench for glyph_bbox_center_core: queued driver, stall-driven monitor.
module glyph_bbox_center_core_test;

    localparam logic KIND_LOAD   = 1'b0;
    localparam logic KIND_READ   = 1'b1;
    localparam int   QUIET_LIMIT = 2000;
    localparam int   HOLD_CYCLES = 120;
    localparam int   ITEM_GOAL   = 450;
    localparam int   FRAME_CAP   = 160;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      drv_valid = 1'b0;
    gbc_pkg::t_in_word         drv_word = '0;
    logic                      in_stall;
    logic                      out_valid;
    gbc_pkg::t_out_word        out_word;
    logic                      out_stall = 1'b1;
    logic                      cfg_we = 1'b0;
    gbc_pkg::t_cfg_idx         cfg_idx = gbc_pkg::CFG_SRC_WIDTH;
    logic [gbc_pkg::CFG_W-1:0] cfg_data = '0;

    glyph_bbox_center_core dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (drv_valid),
        .i_in_data  (drv_word),
        .o_in_stall (in_stall),
        .o_out_valid(out_valid),
        .o_out_data (out_word),
        .i_out_stall(out_stall),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // centering model state
    logic [gbc_pkg::PIX_W-1:0] frame_mem [0:gbc_pkg::MAX_SRC_DIM*gbc_pkg::MAX_SRC_DIM-1];
    logic [gbc_pkg::CFG_W-1:0] src_w_reg, src_h_reg, out_w_reg, out_h_reg;
    int                        ld_col, ld_row, rd_col, rd_row;
    int                        box_l, box_r, box_t, box_b;
    bit                        ld_done, box_seen;
    gbc_pkg::t_out_word        pixels_due [$];

    // stimulus plan and bookkeeping
    gbc_pkg::t_in_word word_q [$];
    int                plan_col, plan_row;
    bit                plan_done;
    int                gx0, gx1, gy0, gy1;
    bit                glyph_blank;
    int                items_sent, items_taken;
    int                loads_seen, reads_seen, frames_seen, dark_frames;
    int                words_checked, images_seen, settings_used, errors;
    int                quiet_cycles;
    bit                in_took, out_took;
    int                tx_wait, rx_wait, hold_left;
    bit                tx_calm, rx_calm;
    int                hold_ask, hold_grant;

    function automatic int eff_dim(logic [gbc_pkg::CFG_W-1:0] v, int top);
        if (v == '0) return 1;
        if (int'(v) > top) return top;
        return int'(v);
    endfunction

    task automatic restart_frame();
        ld_col   = 0;
        ld_row   = 0;
        ld_done  = 1'b0;
        box_seen = 1'b0;
        box_l    = eff_dim(src_w_reg, gbc_pkg::MAX_SRC_DIM);
        box_t    = eff_dim(src_h_reg, gbc_pkg::MAX_SRC_DIM);
        box_r    = 0;
        box_b    = 0;
        rd_col   = 0;
        rd_row   = 0;
    endtask

    task automatic reset_model();
        src_w_reg = gbc_pkg::RST_SRC_DIM;
        src_h_reg = gbc_pkg::RST_SRC_DIM;
        out_w_reg = gbc_pkg::RST_OUT_DIM;
        out_h_reg = gbc_pkg::RST_OUT_DIM;
        restart_frame();
    endtask

    task automatic step_model(gbc_pkg::t_in_word w);
        int                 sw, sh, ow, oh, dx, dy, offx, offy, i, j;
        gbc_pkg::t_out_word r;
        if (w.kind == KIND_LOAD) begin
            sw = eff_dim(src_w_reg, gbc_pkg::MAX_SRC_DIM);
            sh = eff_dim(src_h_reg, gbc_pkg::MAX_SRC_DIM);
            if (ld_done) restart_frame();
            frame_mem[ld_row*gbc_pkg::MAX_SRC_DIM + ld_col] = w.pixel_in;
            loads_seen++;
            if (w.pixel_in == gbc_pkg::PIX_BLACK) begin
                if (!box_seen) begin
                    box_l    = ld_col;
                    box_r    = ld_col;
                    box_t    = ld_row;
                    box_b    = ld_row;
                    box_seen = 1'b1;
                end else begin
                    if (ld_col < box_l) box_l = ld_col;
                    if (ld_col > box_r) box_r = ld_col;
                    if (ld_row < box_t) box_t = ld_row;
                    if (ld_row > box_b) box_b = ld_row;
                end
            end
            if (ld_col + 1 >= sw) begin
                ld_col = 0;
                if (ld_row + 1 >= sh) begin
                    ld_row  = 0;
                    ld_done = 1'b1;
                    frames_seen++;
                    if (box_seen) dark_frames++;
                end else begin
                    ld_row++;
                end
            end else begin
                ld_col++;
            end
        end else begin
            ow          = eff_dim(out_w_reg, gbc_pkg::MAX_OUT_DIM);
            oh          = eff_dim(out_h_reg, gbc_pkg::MAX_OUT_DIM);
            r.pixel_out = gbc_pkg::PIX_WHITE;
            r.last_out  = 1'b0;
            reads_seen++;
            if (ld_done && box_seen) begin
                dx   = box_r - box_l;
                dy   = box_b - box_t;
                offx = (ow - dx) / 2;
                offy = (oh - dy) / 2;
                i    = rd_col - offx;
                j    = rd_row - offy;
                if (i >= 0 && i <= dx && j >= 0 && j <= dy) begin
                    r.pixel_out = frame_mem[(box_t + j)*gbc_pkg::MAX_SRC_DIM + box_l + i];
                end
            end
            if (rd_col + 1 >= ow) begin
                rd_col = 0;
                if (rd_row + 1 >= oh) begin
                    rd_row     = 0;
                    r.last_out = 1'b1;
                end else begin
                    rd_row++;
                end
            end else begin
                rd_col++;
            end
            pixels_due.push_back(r);
        end
    endtask

    task automatic report_miss(string what, logic [gbc_pkg::PIX_W-1:0] got,
                               logic [gbc_pkg::PIX_W-1:0] want);
        errors++;
        $display("mismatch at output word %0d: %s got %h expected %h",
                 words_checked, what, got, want);
    endtask

    task automatic check_word(gbc_pkg::t_out_word got);
        gbc_pkg::t_out_word want;
        if (pixels_due.size() == 0) begin
            report_miss("unrequested word, pixel", got.pixel_out, gbc_pkg::PIX_WHITE);
        end else begin
            want = pixels_due.pop_front();
            if (got.pixel_out !== want.pixel_out) begin
                report_miss("pixel_out", got.pixel_out, want.pixel_out);
            end
            if (got.last_out !== want.last_out) begin
                report_miss("last_out", gbc_pkg::PIX_W'(got.last_out),
                            gbc_pkg::PIX_W'(want.last_out));
            end
            if (want.last_out) images_seen++;
        end
        words_checked++;
    endtask

    always @(posedge clk) begin
        in_took  = rst_n && drv_valid && !in_stall;
        out_took = rst_n && out_valid && !out_stall;
        if (in_took) begin
            step_model(drv_word);
            items_taken++;
        end
        if (out_took) check_word(out_word);
    end

    always @(posedge clk) begin
        if (!rst_n || (drv_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout: no word moved for %0d cycles", QUIET_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // driver
    always @(negedge clk) begin
        logic              nxt_valid;
        gbc_pkg::t_in_word nxt_word;
        nxt_valid = drv_valid;
        nxt_word  = drv_word;
        if (drv_valid && in_took) begin
            nxt_valid = 1'b0;
            tx_wait   = tx_calm ? 0 : $urandom_range(0, 11);
            if ($urandom_range(0, 39) == 0) tx_calm = !tx_calm;
        end
        if (!nxt_valid) begin
            if (tx_wait > 0) begin
                tx_wait--;
            end else if (word_q.size() > 0) begin
                nxt_word  = word_q.pop_front();
                nxt_valid = 1'b1;
            end
        end
        drv_valid <= nxt_valid;
        drv_word  <= nxt_word;
    end

    // receiver stall
    always @(negedge clk) begin
        if (hold_grant != hold_ask) begin
            hold_grant = hold_ask;
            hold_left  = HOLD_CYCLES;
        end
        if (out_took) begin
            rx_wait = rx_calm ? 0 : $urandom_range(0, 11);
            if ($urandom_range(0, 39) == 0) rx_calm = !rx_calm;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end else if (rx_wait > 0) begin
            rx_wait--;
            out_stall <= 1'b1;
        end else begin
            out_stall <= 1'b0;
        end
    end

    task automatic push_load(logic [gbc_pkg::PIX_W-1:0] pix);
        gbc_pkg::t_in_word w;
        int                sw, sh;
        w.kind     = KIND_LOAD;
        w.pixel_in = pix;
        word_q.push_back(w);
        items_sent++;
        sw = eff_dim(src_w_reg, gbc_pkg::MAX_SRC_DIM);
        sh = eff_dim(src_h_reg, gbc_pkg::MAX_SRC_DIM);
        if (plan_done) begin
            plan_col  = 0;
            plan_row  = 0;
            plan_done = 1'b0;
        end
        if (plan_col + 1 >= sw) begin
            plan_col = 0;
            if (plan_row + 1 >= sh) begin
                plan_row  = 0;
                plan_done = 1'b1;
            end else begin
                plan_row++;
            end
        end else begin
            plan_col++;
        end
    endtask

    task automatic push_read();
        gbc_pkg::t_in_word w;
        w.kind     = KIND_READ;
        w.pixel_in = 8'($urandom_range(0, 255));
        word_q.push_back(w);
        items_sent++;
    endtask

    task automatic settle();
        while (!(items_taken == items_sent && pixels_due.size() == 0)) @(negedge clk);
        repeat (8) @(negedge clk);
        plan_col  = ld_col;
        plan_row  = ld_row;
        plan_done = ld_done;
    endtask

    task automatic write_reg(gbc_pkg::t_cfg_idx which, logic [gbc_pkg::CFG_W-1:0] v);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= which;
        cfg_data <= v;
        case (which)
            gbc_pkg::CFG_SRC_WIDTH:  src_w_reg = v;
            gbc_pkg::CFG_SRC_HEIGHT: src_h_reg = v;
            gbc_pkg::CFG_OUT_WIDTH:  out_w_reg = v;
            gbc_pkg::CFG_OUT_HEIGHT: out_h_reg = v;
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [gbc_pkg::CFG_W-1:0] draw_dim();
        int p;
        p = $urandom_range(0, 19);
        if (p == 0) return '0;
        if (p == 1) return gbc_pkg::CFG_W'($urandom_range(65, 127));
        if (p == 2) return gbc_pkg::CFG_W'(64);
        if (p <= 4) return gbc_pkg::CFG_W'(1);
        return gbc_pkg::CFG_W'($urandom_range(2, 9));
    endfunction

    function automatic logic [gbc_pkg::PIX_W-1:0] glyph_pixel(int col, int row);
        if (!glyph_blank && col >= gx0 && col <= gx1 && row >= gy0 && row <= gy1
            && $urandom_range(0, 2) != 0) return gbc_pkg::PIX_BLACK;
        if ($urandom_range(0, 3) == 0) return gbc_pkg::PIX_W'($urandom_range(1, 255));
        return gbc_pkg::PIX_WHITE;
    endfunction

    // completes the frame in progress, or loads a whole new one
    task automatic fill_frame();
        int sw, sh;
        sw          = eff_dim(src_w_reg, gbc_pkg::MAX_SRC_DIM);
        sh          = eff_dim(src_h_reg, gbc_pkg::MAX_SRC_DIM);
        glyph_blank = ($urandom_range(0, 9) == 0);
        gx0         = $urandom_range(0, sw - 1);
        gx1         = $urandom_range(gx0, sw - 1);
        gy0         = $urandom_range(0, sh - 1);
        gy1         = $urandom_range(gy0, sh - 1);
        do begin
            if (plan_done) push_load(glyph_pixel(0, 0));
            else push_load(glyph_pixel(plan_col, plan_row));
        end while (!plan_done);
    endtask

    task automatic reconfigure(int phase);
        logic [gbc_pkg::CFG_W-1:0] nsw, nsh, now_w, noh;
        bit                        row0_change;
        nsw   = src_w_reg;
        nsh   = src_h_reg;
        now_w = out_w_reg;
        noh   = out_h_reg;
        case (phase)
            0: begin
                nsw = 7'd127; nsh = 7'd1; now_w = 7'd65; noh = 7'd1;
            end
            1: begin
                nsw = 7'd1; nsh = 7'd64; now_w = 7'd1; noh = 7'd127;
            end
            2: begin
                nsw = 7'd64; nsh = 7'd2; now_w = 7'd3; noh = 7'd2;
            end
            default: begin
                if ($urandom_range(0, 9) < 4) nsw = draw_dim();
                if ($urandom_range(0, 9) < 4) nsh = draw_dim();
                if ($urandom_range(0, 9) < 4) now_w = draw_dim();
                if ($urandom_range(0, 9) < 4) noh = draw_dim();
            end
        endcase
        // width may only move at a frame boundary or while still on row 0
        if (!plan_done && plan_row != 0) nsw = src_w_reg;
        if (eff_dim(nsw, gbc_pkg::MAX_SRC_DIM) * eff_dim(nsh, gbc_pkg::MAX_SRC_DIM)
            > FRAME_CAP) begin
            nsh = gbc_pkg::CFG_W'($urandom_range(1, 2));
        end
        if (eff_dim(now_w, gbc_pkg::MAX_OUT_DIM) * eff_dim(noh, gbc_pkg::MAX_OUT_DIM)
            > FRAME_CAP) begin
            noh = gbc_pkg::CFG_W'($urandom_range(1, 2));
        end
        row0_change = (nsw != src_w_reg) && !plan_done && plan_col != 0;
        if (nsw != src_w_reg) write_reg(gbc_pkg::CFG_SRC_WIDTH, nsw);
        if (nsh != src_h_reg) write_reg(gbc_pkg::CFG_SRC_HEIGHT, nsh);
        if (now_w != out_w_reg) write_reg(gbc_pkg::CFG_OUT_WIDTH, now_w);
        if (noh != out_h_reg) write_reg(gbc_pkg::CFG_OUT_HEIGHT, noh);
        // rest of a frame whose width moved stays free of dark pixels
        if (row0_change) begin
            while (!plan_done) push_load(gbc_pkg::PIX_W'($urandom_range(1, 255)));
        end
        settings_used++;
    endtask

    task automatic well_formed();
        int n;
        fill_frame();
        if ($urandom_range(0, 3) == 0) fill_frame();
        n = eff_dim(out_w_reg, gbc_pkg::MAX_OUT_DIM) * eff_dim(out_h_reg, gbc_pkg::MAX_OUT_DIM);
        if ($urandom_range(0, 7) == 0) n = $urandom_range(1, n);
        else if ($urandom_range(0, 3) == 0) begin
            n += $urandom_range(1, eff_dim(out_w_reg, gbc_pkg::MAX_OUT_DIM));
        end
        repeat (n) push_read();
    endtask

    task automatic noise_burst();
        repeat ($urandom_range(4, 24)) begin
            if ($urandom_range(0, 1) != 0) begin
                push_read();
            end else begin
                case ($urandom_range(0, 2))
                    0: push_load(gbc_pkg::PIX_BLACK);
                    1: push_load(gbc_pkg::PIX_WHITE);
                    default: push_load(gbc_pkg::PIX_W'($urandom_range(0, 255)));
                endcase
            end
        end
    endtask

    initial begin
        int phase;
        reset_model();
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        settle();

        // reads with no frame loaded
        push_read();
        push_read();
        settle();

        // zero sizes count as one, read counters wrap on a shrunken output
        write_reg(gbc_pkg::CFG_SRC_WIDTH, '0);
        write_reg(gbc_pkg::CFG_SRC_HEIGHT, '0);
        write_reg(gbc_pkg::CFG_OUT_WIDTH, '0);
        write_reg(gbc_pkg::CFG_OUT_HEIGHT, '0);
        settings_used++;
        push_load(gbc_pkg::PIX_BLACK);
        push_read();
        push_load(gbc_pkg::PIX_WHITE);
        push_read();
        settle();

        write_reg(gbc_pkg::CFG_SRC_WIDTH, 7'd3);
        write_reg(gbc_pkg::CFG_SRC_HEIGHT, 7'd2);
        write_reg(gbc_pkg::CFG_OUT_WIDTH, 7'd2);
        write_reg(gbc_pkg::CFG_OUT_HEIGHT, 7'd3);
        settings_used++;
        push_load(8'hAA);
        push_load(gbc_pkg::PIX_BLACK);
        push_load(8'h55);
        push_read();
        // receiver holds off while reads pile up behind it
        @(posedge clk);
        hold_ask++;
        @(negedge clk);
        push_load(gbc_pkg::PIX_BLACK);
        push_load(gbc_pkg::PIX_WHITE);
        push_load(8'h01);
        repeat (6) push_read();

        phase = 0;
        while (items_sent < ITEM_GOAL) begin
            settle();
            reconfigure(phase);
            if (phase < 3 || $urandom_range(0, 9) < 7) well_formed();
            else noise_burst();
            phase++;
        end
        settle();

        $display("covered %0d load and %0d read words, %0d frames (%0d with dark pixels)",
                 loads_seen, reads_seen, frames_seen, dark_frames);
        $display("checked %0d output words, %0d whole images, %0d size settings",
                 words_checked, images_seen, settings_used);
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
